// File: rtl/wslim_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wslim_pkg
// Shared types and constants of the dual-wheel slip current limiter: the
// configuration register indexes and the controller-to-datapath command.
// ----------------------------------------------------------------------------
package wslim_pkg;

  localparam int CFG_ADDR_BITS = 3;

  localparam logic [CFG_ADDR_BITS-1:0] REG_SLIP_LIMIT       = 3'd0;
  localparam logic [CFG_ADDR_BITS-1:0] REG_RECOVER_STEP     = 3'd1;
  localparam logic [CFG_ADDR_BITS-1:0] REG_REDUCE_STEP      = 3'd2;
  localparam logic [CFG_ADDR_BITS-1:0] REG_SCALE_FLOOR      = 3'd3;
  localparam logic [CFG_ADDR_BITS-1:0] REG_ACTIVE_THRESHOLD = 3'd4;

  // One strobe per datapath step.
  typedef struct packed {
    logic load;    // capture input beat, slip product and activity flag
    logic scale;   // update both scale factors
    logic apply;   // multiply targets by the new scales
    logic finish;  // truncate and load the output register
  } wslim_cmd_t;

endpackage : wslim_pkg
`default_nettype wire

// File: rtl/wslim_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wslim_ctrl
// Sequencer of the limiter: steps one tick through load, scale, apply and
// output, and owns the output valid flag.
// ----------------------------------------------------------------------------
module wslim_ctrl
  import wslim_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       s_tvalid,
  output      logic       s_tready,
  output      logic       m_tvalid,
  input  wire logic       m_tready,
  output      wslim_cmd_t cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCALE,
    ST_APPLY,
    ST_OUT
  } state_t;

  state_t state;

  assign s_tready = (state == ST_IDLE);

  always_comb begin
    cmd        = '0;
    cmd.load   = (state == ST_IDLE) && s_tvalid;
    cmd.scale  = (state == ST_SCALE);
    cmd.apply  = (state == ST_APPLY);
    cmd.finish = (state == ST_OUT) && (!m_tvalid || m_tready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (s_tvalid) state <= ST_SCALE;
        end
        ST_SCALE: state <= ST_APPLY;
        ST_APPLY: state <= ST_OUT;
        ST_OUT: begin
          // hold until the output register is free
          if (!m_tvalid || m_tready) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase

      if (cmd.finish) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

endmodule : wslim_ctrl
`default_nettype wire

// File: rtl/wslim_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wslim_dp
// Datapath of the limiter: configuration registers, one lane per wheel with
// slip test, scale update, target scaling and the output register.
// ----------------------------------------------------------------------------
module wslim_dp
  import wslim_pkg::*;
#(
  parameter int CB     = 16,
  parameter int SF     = 10,
  parameter int IN_W   = 64,
  parameter int OUT_W  = 56,
  parameter int CFG_DW = 16
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire wslim_cmd_t               cmd,
  input  wire logic [IN_W-1:0]          s_tdata,
  output      logic [OUT_W-1:0]         m_tdata,
  input  wire logic                     cfg_we,
  input  wire logic [CFG_ADDR_BITS-1:0] cfg_addr,
  input  wire logic [CFG_DW-1:0]        cfg_data
);

  localparam int SB      = SF + 1;          // scale width
  localparam int PW      = SB + CB + 1;     // slip compare width
  localparam int SW      = SB + 2;          // signed scale step width
  localparam int PRW     = CB + SB + 1;     // target * scale width
  localparam int OUT_RAW = 2 * CB + 2 * SB;

  localparam logic [SB-1:0]         UNITY = {1'b1, {SF{1'b0}}};
  localparam logic signed [PRW-1:0] BIAS  = {{(PRW - SF){1'b0}}, {SF{1'b1}}};

  localparam int          SLIP_RST    = (358 << SF) >> 10;
  localparam int          RECOVER_RST = (20 << SF) >> 10;
  localparam int          REDUCE_RST  = (82 << SF) >> 10;
  localparam int          MIN_RST     = (410 << SF) >> 10;
  localparam logic [31:0] THR_RST     = 32'd1280;

  logic [SB-1:0] slip_limit;
  logic [SB-1:0] recover_step;
  logic [SB-1:0] reduce_step;
  logic [SB-1:0] scale_floor;
  logic [CB-1:0] active_threshold;

  always_ff @(posedge clk) begin
    if (rst) begin
      slip_limit       <= SB'(SLIP_RST);
      recover_step     <= SB'(RECOVER_RST);
      reduce_step      <= SB'(REDUCE_RST);
      scale_floor      <= SB'(MIN_RST);
      active_threshold <= THR_RST[CB-1:0];
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_SLIP_LIMIT:       slip_limit       <= cfg_data[SB-1:0];
        REG_RECOVER_STEP:     recover_step     <= cfg_data[SB-1:0];
        REG_REDUCE_STEP:      reduce_step      <= cfg_data[SB-1:0];
        REG_SCALE_FLOOR:      scale_floor      <= cfg_data[SB-1:0];
        REG_ACTIVE_THRESHOLD: active_threshold <= cfg_data[CB-1:0];
        default: ;
      endcase
    end
  end

  // Lower clamp bound, saturated at unity.
  logic [SB-1:0] lo_bound;
  assign lo_bound = (scale_floor > UNITY) ? UNITY : scale_floor;

  logic [SB-1:0] scale  [2];
  logic [CB-1:0] scaled [2];
  logic [SB-1:0] factor [2];
  logic          active [2];

  for (genvar w = 0; w < 2; w++) begin : g_lane
    logic signed [CB-1:0]    tgt_in;
    logic [CB-1:0]           mag;
    logic signed [CB-1:0]    tgt;
    logic signed [CB-1:0]    meas;
    logic [SB+CB-1:0]        sprod;
    logic signed [PW-1:0]    lhs;
    logic signed [PW-1:0]    rhs;
    logic                    slipping;
    logic signed [SW-1:0]    stepped;
    logic [SB-1:0]           scale_next;
    logic signed [PRW-1:0]   prod;
    logic signed [PRW-1:0]   biased;
    logic signed [PRW-1:0]   shifted;

    assign tgt_in = s_tdata[w*CB +: CB];
    // magnitude of the most negative value still fits as unsigned
    assign mag    = tgt_in[CB-1] ? (~tgt_in + CB'(1)) : tgt_in;

    always_ff @(posedge clk) begin
      if (cmd.load) begin
        tgt         <= tgt_in;
        meas        <= s_tdata[(2 + w)*CB +: CB];
        active[w]   <= (mag > active_threshold);
        sprod       <= (SB+CB)'(slip_limit) * (SB+CB)'(mag);
      end
    end

    // measured * UNITY < slip * |target|, signed on both sides
    assign lhs      = {{(PW - CB){meas[CB-1]}}, meas} <<< SF;
    assign rhs      = {1'b0, sprod};
    assign slipping = (lhs < rhs);

    always_comb begin
      if (slipping) begin
        stepped = $signed({2'b00, scale[w]}) - $signed({2'b00, reduce_step});
      end else begin
        stepped = $signed({2'b00, scale[w]}) + $signed({2'b00, recover_step});
      end
      if (!active[w]) begin
        scale_next = UNITY;
      end else if (stepped < $signed({2'b00, lo_bound})) begin
        scale_next = lo_bound;
      end else if (stepped > $signed({2'b00, UNITY})) begin
        scale_next = UNITY;
      end else begin
        scale_next = stepped[SB-1:0];
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        scale[w] <= UNITY;
      end else if (cmd.scale) begin
        scale[w] <= scale_next;
      end
    end

    always_ff @(posedge clk) begin
      if (cmd.apply) begin
        prod <= PRW'(tgt) * PRW'($signed({1'b0, scale[w]}));
      end
    end

    // truncate toward zero: bias negative products before the shift
    assign biased  = prod[PRW-1] ? (prod + BIAS) : prod;
    assign shifted = biased >>> SF;

    always_ff @(posedge clk) begin
      if (cmd.finish) begin
        scaled[w] <= shifted[CB-1:0];
        factor[w] <= scale[w];
      end
    end
  end

  always_comb begin
    m_tdata = '0;
    m_tdata[OUT_RAW-1:0] = {factor[1], factor[0], scaled[1], scaled[0]};
  end

  a_scale_left_max : assert property (@(posedge clk) disable iff (rst)
    scale[0] <= UNITY)
    else $error("left scale above unity");

  a_scale_right_max : assert property (@(posedge clk) disable iff (rst)
    scale[1] <= UNITY)
    else $error("right scale above unity");

  a_idle_left_unity : assert property (@(posedge clk) disable iff (rst)
    cmd.scale && !active[0] |=> scale[0] == UNITY)
    else $error("inactive left wheel did not return to unity");

  a_cmd_exclusive : assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.load, cmd.scale, cmd.apply, cmd.finish}))
    else $error("overlapping datapath commands");

endmodule : wslim_dp
`default_nettype wire

// File: rtl/dual_wheel_slip_current_limiter_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dual_wheel_slip_current_limiter_core
// Per-wheel slip limiter: scales left and right target currents by a factor
// that drops under slip and recovers otherwise.
// ----------------------------------------------------------------------------
// Usage:
//   s_* stream: one beat per control tick, tdata holds target_left,
//   target_right, measured_left, measured_right (CURRENT_BITS each, signed).
//   m_* stream: one beat per tick with scaled_left, scaled_right and the
//   updated factor_left, factor_right.
//   cfg_*: registers written when cfg_we is high; indexes are
//   0 slip limit, 1 recover_step, 2 reduce_step, 3 scale floor,
//   4 active_threshold. Unknown indexes are ignored.
// Sequencing:
//   A beat accepted in ST_IDLE passes through the load, scale update,
//   multiply and output steps, one tick at a time, each registered, before
//   it appears on m_tdata; a new beat is taken only after the last one is out.
//   While the output register holds an untaken beat, the finished tick waits
//   and s_tready stays low.
// Reset:
//   rst returns both scales to unity, registers to their default values, and
//   empties the output register.
// ----------------------------------------------------------------------------
module dual_wheel_slip_current_limiter_core
  import wslim_pkg::*;
#(
  parameter int CURRENT_BITS    = 16,
  parameter int SCALE_FRAC_BITS = 10
) (
  input  wire logic                                    clk,
  input  wire logic                                    rst,
  // target_left, target_right, measured_left, measured_right (low bit up)
  input  wire logic [((4*CURRENT_BITS+7)/8)*8-1:0]     s_tdata,
  input  wire logic                                    s_tvalid,
  output      logic                                    s_tready,
  // scaled_left, scaled_right, factor_left, factor_right (low bit up)
  output      logic [((2*CURRENT_BITS+2*SCALE_FRAC_BITS+2+7)/8)*8-1:0] m_tdata,
  output      logic                                    m_tvalid,
  input  wire logic                                    m_tready,
  input  wire logic                                    cfg_we,
  input  wire logic [CFG_ADDR_BITS-1:0]                cfg_addr,
  input  wire logic [((CURRENT_BITS > SCALE_FRAC_BITS + 1) ?
                      CURRENT_BITS : SCALE_FRAC_BITS + 1)-1:0] cfg_data
);

  localparam int IN_W   = ((4*CURRENT_BITS+7)/8)*8;
  localparam int OUT_W  = ((2*CURRENT_BITS+2*SCALE_FRAC_BITS+2+7)/8)*8;
  localparam int CFG_DW = (CURRENT_BITS > SCALE_FRAC_BITS + 1) ?
                          CURRENT_BITS : SCALE_FRAC_BITS + 1;

  wslim_cmd_t cmd;

  wslim_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd)
  );

  wslim_dp #(
    .CB     (CURRENT_BITS),
    .SF     (SCALE_FRAC_BITS),
    .IN_W   (IN_W),
    .OUT_W  (OUT_W),
    .CFG_DW (CFG_DW)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .s_tdata  (s_tdata),
    .m_tdata  (m_tdata),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data)
  );

endmodule : dual_wheel_slip_current_limiter_core
`default_nettype wire
